[rtl/mjd_seconds_to_calendar_date_macros.svh]
// Assertion macros used by the checker file of the MJD calendar converter.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef MJD_SECONDS_TO_CALENDAR_DATE_MACROS_SVH
`define MJD_SECONDS_TO_CALENDAR_DATE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MJDC_ASSERT_HOLDS(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MJDC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mjdc_pkg.sv]
// Package for the MJD seconds to calendar date converter: payload types,
// reciprocal constants and the month start table. No dependencies.
`default_nettype none

package mjdc_pkg;

    // Configuration space: one 32-bit register, index taken from paddr[2].
    localparam int PADDR_W = 3;
    localparam logic REG_ZONE_OFFSET = 1'b0;
    localparam logic signed [17:0] ZONE_OFFSET_RESET = 18'sd32400;

    // First second of MJD day 2973484 (10000-01-01); fits in 38 bits.
    localparam logic [37:0] LIMIT_SEC = 38'd256909017600;

    // day = ((t >> 7) * DAY_RECIP) >> 41, i.e. t / 86400 for t < 2^38
    localparam logic [31:0] DAY_RECIP = 32'd3257812231;
    localparam logic [9:0]  DAY_BLOCKS = 10'd675;      // 86400 / 128

    // MJD to JDN plus the 68569 bias of the date algorithm
    localparam logic [22:0] JDN_BIAS = 23'd2468570;

    // n = (l * N_RECIP) >> 41 == (4*l) / 146097
    localparam logic [25:0] N_RECIP = 26'd60207212;
    localparam logic [17:0] QUAD_CENT_DAYS = 18'd146097;
    // i = ((l+1) * I_RECIP) >> 37 == (4000*(l+1)) / 1461001
    localparam logic [28:0] I_RECIP = 29'd376287090;
    localparam logic [10:0] QUAD_YEAR_DAYS = 11'd1461;
    // j = (l * J_RECIP) >> 29 == (80*l) / 2447
    localparam logic [24:0] J_RECIP = 25'd17552000;

    // hour = ((sod >> 4) * HOUR_RECIP) >> 21, minute = ((rh >> 2) * MIN_RECIP) >> 14
    localparam logic [13:0] HOUR_RECIP = 14'd9321;
    localparam logic [10:0] MIN_RECIP = 11'd1093;
    localparam logic [16:0] SEC_PER_HOUR = 17'd3600;
    localparam logic [11:0] SEC_PER_MIN = 12'd60;

    typedef struct packed {
        logic [39:0] epoch_seconds;
        logic [31:0] sub_second;
    } mjdc_in_t;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [31:0] second_fraction;
        logic        range_error;
    } mjdc_out_t;

    // Control that rides along the pipeline next to the arithmetic.
    typedef struct packed {
        logic        valid;
        logic        range_err;
        logic [31:0] frac;
    } mjdc_side_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } mjdc_tod_t;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } mjdc_date_t;

    // (2447 * j) / 80: days from the March-based month origin to month j.
    function automatic logic [8:0] month_offset(input logic [3:0] j);
        logic [8:0] r;
        case (j)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd30;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd91;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd152;
            4'd6:    r = 9'd183;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd244;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd305;
            4'd11:   r = 9'd336;
            4'd12:   r = 9'd367;
            4'd13:   r = 9'd397;
            4'd14:   r = 9'd428;
            4'd15:   r = 9'd458;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/mjdc_cfg.sv]
// APB-style configuration register of the MJD calendar converter (zone offset).
// Depends on mjdc_pkg.
`default_nettype none

module mjdc_cfg
    import mjdc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output logic signed [17:0]  zone_offset
);

    logic               reg_idx;
    logic               wr_en;
    logic signed [17:0] zone_reg;
    logic signed [17:0] zone_next;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        zone_next = zone_reg;
        if (wr_en && (reg_idx == REG_ZONE_OFFSET))
        begin
            zone_next = $signed(pwdata[17:0]);
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ZONE_OFFSET: prdata = 32'(zone_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg <= ZONE_OFFSET_RESET;
        end
        else
        begin
            zone_reg <= zone_next;
        end
    end

    assign zone_offset = zone_reg;

endmodule

`default_nettype wire

[rtl/mjdc_split.sv]
// Stages 1-3: zone shift, range checks, split into MJD day and seconds of day.
// Depends on mjdc_pkg.
`default_nettype none

module mjdc_split
    import mjdc_pkg::*;
#(
    parameter int SECONDS_BITS = 40
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  mjdc_in_t           item,
    input  logic signed [17:0] zone_offset,
    output logic [16:0]        sod,
    output logic [22:0]        jdn_l,
    output mjdc_side_t         side
);

    localparam int EW = (SECONDS_BITS < 40) ? SECONDS_BITS : 40;
    localparam int SW = SECONDS_BITS + 2;
    localparam int TW = (SECONDS_BITS + 1 > 38) ? SECONDS_BITS + 1 : 38;

    logic [SECONDS_BITS-1:0] epoch;
    logic signed [SW-1:0]    shifted;
    logic [TW-1:0]           t_next,  t_reg;
    mjdc_side_t              side1_next, side1_reg;

    logic                    past_limit;
    logic [62:0]             day_prod;
    logic [21:0]             day_next, day_reg;
    logic [16:0]             tlow_next, tlow_reg;
    mjdc_side_t              side2_next, side2_reg;

    logic [31:0]             blk_prod;
    logic [9:0]              blk_rem;
    logic [16:0]             sod_next, sod_reg;
    logic [22:0]             l0_next, l0_reg;
    mjdc_side_t              side3_reg;

    // stage 1: signed add; the top bit flags a negative shifted time
    always_comb
    begin
        epoch   = SECONDS_BITS'(item.epoch_seconds[EW-1:0]);
        shifted = $signed({2'b00, epoch}) + SW'(zone_offset);
        t_next  = TW'(shifted[SECONDS_BITS:0]);
        side1_next.valid     = accept;
        side1_next.range_err = shifted[SW-1];
        side1_next.frac      = item.sub_second;
    end

    // stage 2: limit compare, day by reciprocal multiply
    always_comb
    begin
        past_limit = (t_reg >= TW'(LIMIT_SEC));
        day_prod   = 63'(t_reg[37:7]) * 63'(DAY_RECIP);
        day_next   = day_prod[62:41];
        tlow_next  = t_reg[16:0];
        side2_next = side1_reg;
        side2_next.range_err = side1_reg.range_err | past_limit;
    end

    // stage 3: seconds of day from the low remainder; bias the day number
    always_comb
    begin
        blk_prod = 32'(day_reg) * 32'(DAY_BLOCKS);
        blk_rem  = tlow_reg[16:7] - blk_prod[9:0];
        sod_next = {blk_rem, tlow_reg[6:0]};
        l0_next  = 23'(day_reg) + JDN_BIAS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side1_reg <= '0;
            side2_reg <= '0;
            side3_reg <= '0;
        end
        else
        begin
            side1_reg <= side1_next;
            side2_reg <= side2_next;
            side3_reg <= side2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg    <= t_next;
        day_reg  <= day_next;
        tlow_reg <= tlow_next;
        sod_reg  <= sod_next;
        l0_reg   <= l0_next;
    end

    assign sod   = sod_reg;
    assign jdn_l = l0_reg;
    assign side  = side3_reg;

endmodule

`default_nettype wire

[rtl/mjdc_tod.sv]
// Stages 4-9: hour, minute and second from seconds of day, delayed to stage 9.
// Depends on mjdc_pkg.
`default_nettype none

module mjdc_tod
    import mjdc_pkg::*;
(
    input  logic        clk,
    input  logic [16:0] sod,
    output mjdc_tod_t   tod
);

    logic [26:0] hr_prod;
    logic [4:0]  hr4_reg, hr5_reg, hr6_reg;
    logic [16:0] sod4_reg;
    logic [16:0] hr_secs;
    logic [11:0] rh5_next, rh5_reg, rh6_reg;
    logic [20:0] mn_prod;
    logic [5:0]  mn6_reg;
    logic [11:0] mn_secs;
    mjdc_tod_t   tod7_next, tod7_reg, tod8_reg, tod9_reg;

    always_comb
    begin
        hr_prod  = 27'(sod[16:4]) * 27'(HOUR_RECIP);
        hr_secs  = 17'(hr4_reg) * SEC_PER_HOUR;
        rh5_next = 12'(sod4_reg - hr_secs);
        mn_prod  = 21'(rh5_reg[11:2]) * 21'(MIN_RECIP);
        mn_secs  = 12'(mn6_reg) * SEC_PER_MIN;
        tod7_next.hour   = hr6_reg;
        tod7_next.minute = mn6_reg;
        tod7_next.second = 6'(rh6_reg - mn_secs);
    end

    always_ff @(posedge clk)
    begin
        hr4_reg  <= hr_prod[25:21];
        sod4_reg <= sod;
        hr5_reg  <= hr4_reg;
        rh5_reg  <= rh5_next;
        hr6_reg  <= hr5_reg;
        rh6_reg  <= rh5_reg;
        mn6_reg  <= mn_prod[19:14];
        tod7_reg <= tod7_next;
        tod8_reg <= tod7_reg;
        tod9_reg <= tod8_reg;
    end

    assign tod = tod9_reg;

endmodule

`default_nettype wire

[rtl/mjdc_date.sv]
// Stages 4-9: Fliegel-Van Flandern day number to Gregorian year, month, day.
// Depends on mjdc_pkg.
`default_nettype none

module mjdc_date
    import mjdc_pkg::*;
(
    input  logic        clk,
    input  logic [22:0] jdn_l,
    output mjdc_date_t  date
);

    logic [48:0] n_prod;
    logic [7:0]  n4_reg, n5_reg, n6_reg, n7_reg, n8_reg;
    logic [22:0] l0_4_reg;
    logic [25:0] n_days;
    logic [15:0] l1_next, l1_5_reg, l1_6_reg;
    logic [16:0] l1_inc;
    logic [45:0] i_prod;
    logic [6:0]  i6_reg, i7_reg, i8_reg;
    logic [17:0] i_days;
    logic [9:0]  l2_next, l2_7_reg, l2_8_reg;
    logic [34:0] j_prod;
    logic [3:0]  j8_reg;
    logic        k_wrap;
    mjdc_date_t  date_next, date_reg;

    always_comb
    begin
        // n: century count
        n_prod  = 49'(jdn_l) * 49'(N_RECIP);
        // l1: day within the century
        n_days  = 26'(n4_reg) * 26'(QUAD_CENT_DAYS) + 26'd3;
        l1_next = 16'(l0_4_reg - 23'(n_days[25:2]));
        // i: year within the century
        l1_inc  = 17'(l1_5_reg) + 17'd1;
        i_prod  = 46'(l1_inc) * 46'(I_RECIP);
        // l2: March-based day of year, plus 31
        i_days  = 18'(i6_reg) * 18'(QUAD_YEAR_DAYS);
        l2_next = 10'(18'(l1_6_reg) - 18'(i_days[17:2]) + 18'd31);
        // j: March-based month index
        j_prod  = 35'(l2_7_reg) * 35'(J_RECIP);
        // January and February roll into the next year
        k_wrap  = (j8_reg >= 4'd11);
        date_next.day   = 5'(l2_8_reg - 10'(month_offset(j8_reg)));
        date_next.month = k_wrap ? (j8_reg - 4'd10) : (j8_reg + 4'd2);
        date_next.year  = 14'(14'(n8_reg) * 14'd100 + 14'(i8_reg) + 14'(k_wrap)
                              - 14'd4900);
    end

    always_ff @(posedge clk)
    begin
        n4_reg   <= n_prod[48:41];
        l0_4_reg <= jdn_l;
        n5_reg   <= n4_reg;
        l1_5_reg <= l1_next;
        n6_reg   <= n5_reg;
        l1_6_reg <= l1_5_reg;
        i6_reg   <= i_prod[43:37];
        n7_reg   <= n6_reg;
        i7_reg   <= i6_reg;
        l2_7_reg <= l2_next;
        n8_reg   <= n7_reg;
        i8_reg   <= i7_reg;
        l2_8_reg <= l2_7_reg;
        j8_reg   <= j_prod[32:29];
        date_reg <= date_next;
    end

    assign date = date_reg;

endmodule

`default_nettype wire

[rtl/mjd_seconds_to_calendar_date.sv]
// Top level of the MJD seconds to calendar date converter.
// Depends on mjdc_pkg, mjdc_cfg, mjdc_split, mjdc_tod and mjdc_date.
//
//  Channel  | Handshake              | Payload             | Notes
//  ---------+------------------------+---------------------+---------------------------
//  input    | start, busy            | item (mjdc_in_t)    | taken when start && !busy
//  result   | done (1-cycle strobe)  | result (mjdc_out_t) | one per input transaction
//  config   | psel/penable/pwrite    | paddr, pwdata       | prdata readback, pready = 1
//
// Fully pipelined: one transaction per clock, results in order.
// The pipeline depth is set by the date chain (three reciprocal multiplies,
// each registered, plus the day split and the output register).
// busy never rises: the result side cannot stall, so nothing backs up.
// rst_n clears the valid bits and loads the zone offset with +9 hours.
`default_nettype none

module mjd_seconds_to_calendar_date
    import mjdc_pkg::*;
#(
    parameter int SECONDS_BITS = 40
)
(
    input  logic               clk,
    input  logic               rst_n,
    // input transaction
    input  logic               start,
    output logic               busy,
    input  mjdc_in_t           item,
    // result transaction
    output logic               done,
    output mjdc_out_t          result,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // stages 4..9 of the side band (valid, error, fraction)
    localparam int SIDE_STAGES = 6;

    logic               accept;
    logic signed [17:0] zone_offset;
    logic [16:0]        sod;
    logic [22:0]        jdn_l;
    mjdc_side_t         side3;
    mjdc_tod_t          tod9;
    mjdc_date_t         date9;
    mjdc_side_t         side_pipe_reg [SIDE_STAGES];
    mjdc_side_t         side9;
    logic               done_reg;
    mjdc_out_t          result_next, result_reg;

    // the pipeline always advances
    assign busy   = 1'b0;
    assign accept = start && !busy;

    mjdc_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .zone_offset (zone_offset)
    );

    // stages 1-3: shift by zone, out-of-range flags, day / seconds-of-day
    mjdc_split #(
        .SECONDS_BITS (SECONDS_BITS)
    ) u_split (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (item),
        .zone_offset (zone_offset),
        .sod         (sod),
        .jdn_l       (jdn_l),
        .side        (side3)
    );

    // stages 4-9: time of day, runs beside the date chain
    mjdc_tod u_tod (
        .clk (clk),
        .sod (sod),
        .tod (tod9)
    );

    // stages 4-9: calendar date
    mjdc_date u_date (
        .clk   (clk),
        .jdn_l (jdn_l),
        .date  (date9)
    );

    // side band keeps step with the two arithmetic chains
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SIDE_STAGES; s++)
            begin
                side_pipe_reg[s] <= '0;
            end
        end
        else
        begin
            side_pipe_reg[0] <= side3;
            for (int s = 1; s < SIDE_STAGES; s++)
            begin
                side_pipe_reg[s] <= side_pipe_reg[s-1];
            end
        end
    end

    assign side9 = side_pipe_reg[SIDE_STAGES-1];

    // an out-of-range time returns all-zero fields with the flag set
    always_comb
    begin
        result_next = '0;
        if (side9.range_err)
        begin
            result_next.range_error = 1'b1;
        end
        else
        begin
            result_next.year            = date9.year;
            result_next.month           = date9.month;
            result_next.day_of_month    = date9.day;
            result_next.hour            = tod9.hour;
            result_next.minute          = tod9.minute;
            result_next.second          = tod9.second;
            result_next.second_fraction = side9.frac;
            result_next.range_error     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= side9.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

[rtl/mjdc_checker.sv]
// Port-level checker for the MJD calendar converter, bound to the top level.
// Depends on mjdc_pkg and mjd_seconds_to_calendar_date_macros.svh.
`default_nettype none

`include "mjd_seconds_to_calendar_date_macros.svh"

module mjdc_checker
    import mjdc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input mjdc_in_t  item,
    input logic      done,
    input mjdc_out_t result
);

    localparam int LATENCY = 10;

    `MJDC_ASSERT_HOLDS(a_never_busy, 1'b1, !busy, "busy raised by a non-stalling pipeline")

    // cycles before the first clock have no history and count as idle
    `MJDC_ASSERT_NEXT(a_done_latency, 1'b1, done == ($past(start && !busy && rst_n, LATENCY) === 1'b1), "done does not match the accepted transaction ten clocks earlier")

    `MJDC_ASSERT_HOLDS(a_error_zeroes, done && result.range_error, result.year == 14'd0 && result.month == 4'd0 && result.day_of_month == 5'd0 && result.hour == 5'd0 && result.minute == 6'd0 && result.second == 6'd0 && result.second_fraction == 32'd0, "range error result carries nonzero fields")

    `MJDC_ASSERT_HOLDS(a_fields_legal, done && !result.range_error, result.year <= 14'd9999 && result.month >= 4'd1 && result.month <= 4'd12 && result.day_of_month >= 5'd1 && result.hour <= 5'd23 && result.minute <= 6'd59 && result.second <= 6'd59, "calendar field out of its legal range")

    `MJDC_ASSERT_HOLDS(a_fraction_passes, done && !result.range_error, result.second_fraction == $past(item.sub_second, LATENCY), "fraction does not follow its transaction")

endmodule

bind mjd_seconds_to_calendar_date mjdc_checker u_checker (.*);

`default_nettype wire
